### design/tas_pkg.sv
// ============================================================================
// tas_pkg
// Shared types and constants of the texture address sampler: store sizes,
// field widths, address mode and register codes, and the classified item.
// ============================================================================
`default_nettype none

package tas_pkg;

    localparam int MAX_DIM     = 256;
    localparam int STORE_DEPTH = 65536;

    localparam int TEXEL_W     = 32;
    localparam int COORD_IN_W  = 16;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int SIZE_REG_W  = 9;
    localparam int MODE_REG_W  = 2;

    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int COORD_W     = $clog2(MAX_DIM);
    localparam int DIV_W       = DIM_W + 1;
    localparam int IDX_W       = $clog2(MAX_DIM * MAX_DIM);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int MOD_BITS    = 4;
    localparam int MOD_STAGES  = COORD_IN_W / MOD_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [MODE_REG_W-1:0] {
        AM_WRAP,
        AM_MIRROR,
        AM_CLAMP,
        AM_BORDER
    } t_addr_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADDRESS_MODE,
        CFG_BORDER_COLOR,
        CFG_TEX_WIDTH,
        CFG_TEX_HEIGHT
    } t_cfg_index;

    typedef struct packed {
        t_addr_mode              address_mode;
        logic [TEXEL_W-1:0]      border_color;
        logic [SIZE_REG_W-1:0]   tex_width;
        logic [SIZE_REG_W-1:0]   tex_height;
    } t_cfg;

    typedef struct packed {
        logic                    sample;
        logic                    in_image;
        logic                    u_neg;
        logic                    v_neg;
        logic [COORD_IN_W-1:0]   u_abs;
        logic [COORD_IN_W-1:0]   v_abs;
        logic [COORD_W-1:0]      u_clamp;
        logic [COORD_W-1:0]      v_clamp;
        logic [DIM_W-1:0]        w;
        logic [DIM_W-1:0]        h;
        logic [DIV_W-1:0]        u_div;
        logic [DIV_W-1:0]        v_div;
        logic [TEXEL_W-1:0]      texel;
    } t_item;

endpackage

`default_nettype wire

### design/tas_front.sv
// ============================================================================
// tas_front
// Accepts items and classifies them: effective image size, sign and magnitude
// of each coordinate, clamped coordinates, inside test and modulo divisors.
// ============================================================================
`default_nettype none

module tas_front import tas_pkg::*; (
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic signed [COORD_IN_W-1:0] i_coord_u,
    input  logic signed [COORD_IN_W-1:0] i_coord_v,
    input  logic [TEXEL_W-1:0]           i_texel_in,
    input  t_cfg                         i_cfg,
    input  logic                         i_queue_ready,
    output logic                         o_push,
    output t_item                        o_item
);

    function automatic logic [DIM_W-1:0] eff_size(logic [SIZE_REG_W-1:0] s);
        logic [DIM_W-1:0] r;
        if (s == '0) begin
            r = DIM_W'(1);
        end else if (32'(s) > 32'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(s);
        end
        return r;
    endfunction

    logic [DIM_W-1:0]      w;
    logic [DIM_W-1:0]      h;
    logic                  u_neg;
    logic                  v_neg;
    logic [COORD_IN_W-1:0] u_abs;
    logic [COORD_IN_W-1:0] v_abs;
    logic                  u_in;
    logic                  v_in;
    logic                  mirror;

    always_comb begin
        w      = eff_size(i_cfg.tex_width);
        h      = eff_size(i_cfg.tex_height);
        mirror = (i_cfg.address_mode == AM_MIRROR);
        u_neg  = i_coord_u[COORD_IN_W-1];
        v_neg  = i_coord_v[COORD_IN_W-1];
        u_abs  = u_neg ? COORD_IN_W'(-i_coord_u) : COORD_IN_W'(i_coord_u);
        v_abs  = v_neg ? COORD_IN_W'(-i_coord_v) : COORD_IN_W'(i_coord_v);
        u_in   = !u_neg && (u_abs < COORD_IN_W'(w));
        v_in   = !v_neg && (v_abs < COORD_IN_W'(h));

        o_item.sample   = i_mode;
        o_item.in_image = u_in && v_in;
        o_item.u_neg    = u_neg;
        o_item.v_neg    = v_neg;
        o_item.u_abs    = u_abs;
        o_item.v_abs    = v_abs;
        o_item.u_clamp  = u_neg ? '0 : (u_in ? COORD_W'(u_abs) : COORD_W'(w - DIM_W'(1)));
        o_item.v_clamp  = v_neg ? '0 : (v_in ? COORD_W'(v_abs) : COORD_W'(h - DIM_W'(1)));
        o_item.w        = w;
        o_item.h        = h;
        o_item.u_div    = mirror ? {w, 1'b0} : {1'b0, w};
        o_item.v_div    = mirror ? {h, 1'b0} : {1'b0, h};
        o_item.texel    = i_texel_in;
    end

    assign o_ready = i_queue_ready;
    assign o_push  = i_valid && i_queue_ready;

endmodule

`default_nettype wire

### design/tas_queue.sv
// ============================================================================
// tas_queue
// Short queue of classified items between the front and the back, so that
// each side can stall on its own.
// ============================================================================
`default_nettype none

module tas_queue import tas_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_pop_ready,
    output t_item o_item
);

    t_item              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               pop;

    function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
        return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_ready = (32'(r_count) < QUEUE_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_item  = r_entry[r_rd_ptr];
    assign pop     = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= QUEUE_DEPTH)
        else $error("Queue fill count exceeds its depth.");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !pop |=> r_count == $past(r_count) + QCNT_W'(1))
        else $error("Queue did not grow on a push without a pop.");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !i_push |=> r_count == $past(r_count) - QCNT_W'(1))
        else $error("Queue did not shrink on a pop without a push.");

endmodule

`default_nettype wire

### design/tas_mod_unit.sv
// ============================================================================
// tas_mod_unit
// Pipelined restoring remainder unit: the magnitude of a coordinate modulo a
// divisor, a few dividend bits per stage.
// ============================================================================
`default_nettype none

module tas_mod_unit import tas_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [COORD_IN_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]      i_divisor,
    output logic [DIV_W-1:0]      o_rem
);

    function automatic logic [DIV_W-1:0] rem_step(
        logic [DIV_W-1:0]    rem,
        logic [MOD_BITS-1:0] bits,
        logic [DIV_W-1:0]    d
    );
        logic [DIV_W:0]   acc;
        logic [DIV_W-1:0] r;
        r = rem;
        for (int k = MOD_BITS - 1; k >= 0; k--) begin
            acc = {r, bits[k]};
            if (acc >= {1'b0, d}) begin
                acc = acc - {1'b0, d};
            end
            r = acc[DIV_W-1:0];
        end
        return r;
    endfunction

    logic [DIV_W-1:0]      r_rem [MOD_STAGES];
    logic [COORD_IN_W-1:0] r_dvd [MOD_STAGES];
    logic [DIV_W-1:0]      r_div [MOD_STAGES];
    logic [DIV_W-1:0]      n_rem [MOD_STAGES];
    logic [COORD_IN_W-1:0] n_dvd [MOD_STAGES];
    logic [DIV_W-1:0]      n_div [MOD_STAGES];

    always_comb begin
        n_rem[0] = rem_step('0, i_dividend[COORD_IN_W-1 -: MOD_BITS], i_divisor);
        n_dvd[0] = i_dividend << MOD_BITS;
        n_div[0] = i_divisor;
        for (int s = 1; s < MOD_STAGES; s++) begin
            n_rem[s] = rem_step(r_rem[s-1], r_dvd[s-1][COORD_IN_W-1 -: MOD_BITS],
                                r_div[s-1]);
            n_dvd[s] = r_dvd[s-1] << MOD_BITS;
            n_div[s] = r_div[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
            r_div <= n_div;
        end
    end

    assign o_rem = r_rem[MOD_STAGES-1];

endmodule

`default_nettype wire

### design/tas_back.sv
// ============================================================================
// tas_back
// Carries out classified items: coordinate remainders, address mode mapping,
// texel address, texel store access and the result register.
// ============================================================================
`default_nettype none

module tas_back import tas_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_item_valid,
    output logic               o_item_ready,
    input  t_item              i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [TEXEL_W-1:0] o_texel_out,
    output logic               o_used_border,
    output logic               o_write_ok
);

    function automatic logic [COORD_W-1:0] fix_axis(
        logic [DIV_W-1:0] rem,
        logic             neg,
        logic [DIV_W-1:0] m,
        logic [DIM_W-1:0] n,
        logic             mirror
    );
        logic [DIV_W-1:0] p;
        p = (neg && rem != '0) ? m - rem : rem;
        if (mirror && p >= {1'b0, n}) begin
            p = m - DIV_W'(1) - p;
        end
        return COORD_W'(p);
    endfunction

    logic             en;
    logic             r_r_valid;
    logic [DIV_W-1:0] u_rem;
    logic [DIV_W-1:0] v_rem;

    assign en           = !r_r_valid || i_ready;
    assign o_item_ready = en;

    tas_mod_unit u_mod_u (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (i_item.u_abs),
        .i_divisor  (i_item.u_div),
        .o_rem      (u_rem)
    );

    tas_mod_unit u_mod_v (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_dividend (i_item.v_abs),
        .i_divisor  (i_item.v_div),
        .o_rem      (v_rem)
    );

    // Item fields travel alongside the remainder stages.
    t_item                 r_m_item [MOD_STAGES];
    logic [MOD_STAGES-1:0] r_m_valid;
    t_item                 m_item;

    assign m_item = r_m_item[MOD_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= '0;
        end else if (en) begin
            r_m_valid[0] <= i_item_valid;
            for (int s = 1; s < MOD_STAGES; s++) begin
                r_m_valid[s] <= r_m_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_item[0] <= i_item;
            for (int s = 1; s < MOD_STAGES; s++) begin
                r_m_item[s] <= r_m_item[s-1];
            end
        end
    end

    // Address mode mapping.
    logic [COORD_W-1:0] n_f_u;
    logic [COORD_W-1:0] n_f_v;
    logic               n_f_border;
    logic               n_f_write;

    always_comb begin
        n_f_u      = m_item.u_clamp;
        n_f_v      = m_item.v_clamp;
        n_f_border = 1'b0;
        n_f_write  = !m_item.sample && m_item.in_image;
        if (m_item.sample) begin
            unique case (i_cfg.address_mode)
                AM_WRAP: begin
                    n_f_u = fix_axis(u_rem, m_item.u_neg, m_item.u_div, m_item.w, 1'b0);
                    n_f_v = fix_axis(v_rem, m_item.v_neg, m_item.v_div, m_item.h, 1'b0);
                end
                AM_MIRROR: begin
                    n_f_u = fix_axis(u_rem, m_item.u_neg, m_item.u_div, m_item.w, 1'b1);
                    n_f_v = fix_axis(v_rem, m_item.v_neg, m_item.v_div, m_item.h, 1'b1);
                end
                AM_CLAMP: begin
                    n_f_u = m_item.u_clamp;
                    n_f_v = m_item.v_clamp;
                end
                AM_BORDER: begin
                    n_f_border = !m_item.in_image;
                end
                default: begin
                    n_f_border = 1'b0;
                end
            endcase
        end
    end

    logic               r_f_valid;
    logic [COORD_W-1:0] r_f_u;
    logic [COORD_W-1:0] r_f_v;
    logic [DIM_W-1:0]   r_f_w;
    logic [DIM_W-1:0]   r_f_h;
    logic               r_f_sample;
    logic               r_f_border;
    logic               r_f_write;
    logic [TEXEL_W-1:0] r_f_texel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_m_valid[MOD_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_u      <= n_f_u;
            r_f_v      <= n_f_v;
            r_f_w      <= m_item.w;
            r_f_h      <= m_item.h;
            r_f_sample <= m_item.sample;
            r_f_border <= n_f_border;
            r_f_write  <= n_f_write;
            r_f_texel  <= m_item.texel;
        end
    end

    // Texel address: row times stride plus column.
    logic [IDX_W-1:0] n_a_idx;

    assign n_a_idx = IDX_W'(r_f_v) * IDX_W'(r_f_w) + IDX_W'(r_f_u);

    logic               r_a_valid;
    logic [ADDR_W-1:0]  r_a_addr;
    logic               r_a_in_store;
    logic               r_a_sample;
    logic               r_a_border;
    logic               r_a_write;
    logic [TEXEL_W-1:0] r_a_texel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_addr     <= ADDR_W'(n_a_idx);
            r_a_in_store <= (64'(n_a_idx) < 64'(STORE_DEPTH));
            r_a_sample   <= r_f_sample;
            r_a_border   <= r_f_border;
            r_a_write    <= r_f_write;
            r_a_texel    <= r_f_texel;
        end
    end

    // Texel store and result register.
    logic [TEXEL_W-1:0] r_texel_mem [STORE_DEPTH];
    logic [TEXEL_W-1:0] r_r_rdata;
    logic               r_r_border;
    logic               r_r_read;
    logic               r_r_write_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (en) begin
            r_r_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_a_valid && r_a_write && r_a_in_store) begin
                r_texel_mem[r_a_addr] <= r_a_texel;
            end
            r_r_rdata    <= r_texel_mem[r_a_addr];
            r_r_border   <= r_a_sample && r_a_border;
            r_r_read     <= r_a_sample && !r_a_border && r_a_in_store;
            r_r_write_ok <= r_a_write && r_a_in_store;
        end
    end

    assign o_valid       = r_r_valid;
    assign o_texel_out   = r_r_border ? i_cfg.border_color : (r_r_read ? r_r_rdata : '0);
    assign o_used_border = r_r_border;
    assign o_write_ok    = r_r_write_ok;

    a_u_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_valid && r_f_sample && !r_f_border |-> DIM_W'(r_f_u) < r_f_w)
        else $error("Mapped horizontal coordinate lies outside the image.");

    a_v_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_valid && r_f_sample && !r_f_border |-> DIM_W'(r_f_v) < r_f_h)
        else $error("Mapped vertical coordinate lies outside the image.");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_r_valid |-> !(r_r_write_ok && (r_r_border || r_r_read)))
        else $error("A result is flagged both as a write and as a sample.");

endmodule

`default_nettype wire

### design/texture_address_sampler.sv
// ============================================================================
// texture_address_sampler
// Texel store with a texture address unit supporting wrap, mirror, clamp and
// border addressing.
// ============================================================================
// The block holds a 65536-entry store of 32-bit RGBA texels laid out row by
// row with a stride of the effective tex_width. A write item stores a texel
// at u,v and reports whether it landed inside the image; a sample item maps
// u,v by the configured address mode and returns the texel or the border
// color. The block sustains one item per clock cycle when the output is not
// stalled; each item passes a two-entry input queue, a four-stage remainder
// pipeline (four coordinate bits per stage), a mapping stage, an address
// stage and the store access. The store has one port and serves one write or
// one read per cycle. Texels must be written before they are sampled;
// unwritten entries read as undefined. The user must write configuration
// only while no item is in flight; the block itself does not enforce this.
// ============================================================================
`default_nettype none

module texture_address_sampler import tas_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic signed [COORD_IN_W-1:0] i_coord_u,
    input  logic signed [COORD_IN_W-1:0] i_coord_v,
    input  logic [TEXEL_W-1:0]           i_texel_in,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [TEXEL_W-1:0]           o_texel_out,
    output logic                         o_used_border,
    output logic                         o_write_ok,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_wdata
);

    t_cfg  r_cfg;
    t_item front_item;
    t_item queue_item;
    logic  front_push;
    logic  queue_ready;
    logic  queue_valid;
    logic  back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.address_mode <= AM_WRAP;
            r_cfg.border_color <= '0;
            r_cfg.tex_width    <= SIZE_REG_W'(256);
            r_cfg.tex_height   <= SIZE_REG_W'(256);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ADDRESS_MODE: r_cfg.address_mode <= t_addr_mode'(i_cfg_wdata[MODE_REG_W-1:0]);
                CFG_BORDER_COLOR: r_cfg.border_color <= i_cfg_wdata[TEXEL_W-1:0];
                CFG_TEX_WIDTH:    r_cfg.tex_width    <= i_cfg_wdata[SIZE_REG_W-1:0];
                CFG_TEX_HEIGHT:   r_cfg.tex_height   <= i_cfg_wdata[SIZE_REG_W-1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    tas_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_coord_u     (i_coord_u),
        .i_coord_v     (i_coord_v),
        .i_texel_in    (i_texel_in),
        .i_cfg         (r_cfg),
        .i_queue_ready (queue_ready),
        .o_push        (front_push),
        .o_item        (front_item)
    );

    tas_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_push),
        .i_item      (front_item),
        .o_ready     (queue_ready),
        .o_valid     (queue_valid),
        .i_pop_ready (back_ready),
        .o_item      (queue_item)
    );

    tas_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_item_valid  (queue_valid),
        .o_item_ready  (back_ready),
        .i_item        (queue_item),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_texel_out   (o_texel_out),
        .o_used_border (o_used_border),
        .o_write_ok    (o_write_ok)
    );

endmodule

`default_nettype wire
